// ===== hdl/hcct_pkg.sv =====
// ----------------------------------------------------------------------------
// HCI command credit tracker package
// Shared codes, constants and control bundles for the credit tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package hcct_pkg;

   localparam logic [1:0]  MODE_SUBMIT      = 2'd0;
   localparam logic [1:0]  MODE_EVENT       = 2'd1;
   localparam logic [1:0]  MODE_TICK        = 2'd2;

   localparam logic [7:0]  EVT_CMD_COMPLETE = 8'h0E;
   localparam logic [7:0]  EVT_CMD_STATUS   = 8'h0F;
   localparam logic [15:0] NULL_OPCODE      = 16'h0000;
   localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUBMIT,
      ST_MATCH,
      ST_EXPIRE,
      ST_ISSUE,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/hcct_cell.sv =====
// ----------------------------------------------------------------------------
// Outstanding table cell
// Holds one outstanding opcode and its issue tick; loads a new entry or takes
// the entry of its upper neighbor when the table closes a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module hcct_cell #(
   parameter int TICK_WIDTH = 32
) (
   input  wire                       clock,
   input  hcct_pkg::cell_ctrl_type   ctrl,
   input  wire [15:0]                load_opcode,
   input  wire [TICK_WIDTH-1:0]      load_tick,
   input  wire [15:0]                next_opcode,
   input  wire [TICK_WIDTH-1:0]      next_tick,
   input  wire [15:0]                match_opcode,
   output logic [15:0]               opcode,
   output logic [TICK_WIDTH-1:0]     tick,
   output logic                      match
);
   import hcct_pkg::*;

   logic [15:0]           opcode_ff;
   logic [15:0]           opcode_in;
   logic [TICK_WIDTH-1:0] tick_ff;
   logic [TICK_WIDTH-1:0] tick_in;

   always_comb begin
      opcode_in = opcode_ff;
      tick_in   = tick_ff;
      if (ctrl.load) begin
         opcode_in = load_opcode;
         tick_in   = load_tick;
      end else if (ctrl.shift) begin
         opcode_in = next_opcode;
         tick_in   = next_tick;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff <= opcode_in;
      tick_ff   <= tick_in;
   end

   assign opcode = opcode_ff;
   assign tick   = tick_ff;
   assign match  = (opcode_ff == match_opcode);

endmodule

`default_nettype wire

// ===== hdl/hcct_fifo.sv =====
// ----------------------------------------------------------------------------
// Pending command FIFO
// Circular opcode store with registered head read and an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module hcct_fifo #(
   parameter int DEPTH = 16,
   parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  wire                      clock,
   input  wire                      reset,
   input  hcct_pkg::fifo_ctrl_type  ctrl,
   input  wire [15:0]               push_data,
   output logic [15:0]              head_data,
   output logic [CW-1:0]            count
);
   import hcct_pkg::*;

   logic [15:0]   mem [DEPTH];
   logic [15:0]   head_data_ff;
   logic [IW-1:0] head_ff;
   logic [IW-1:0] head_in;
   logic [IW-1:0] tail_ff;
   logic [IW-1:0] tail_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctrl.push) begin
         tail_in  = (tail_ff == IW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         head_in  = (head_ff == IW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= push_data;
      end
      head_data_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign head_data = head_data_ff;
   assign count     = count_ff;

endmodule

`default_nettype wire

// ===== hdl/hci_command_credit_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// HCI command credit tracker
// Host-side command flow control: issues, queues or drops submitted commands,
// retires them on controller events and expires them on time ticks and events.
// ----------------------------------------------------------------------------
// Each request beat on req_ carries a submit (tuser 0), a controller event
// (tuser 1) or a time tick (tuser 2); every request beat yields exactly one
// response beat on rsp_ with the issue decision, flags and updated counts.
// Write the timeout register through csr_wen and csr_wdata only while idle;
// the block does not enforce this. A submit or an unused code goes through
// ST_SUBMIT or ST_REPORT to the response register, an event through ST_MATCH,
// ST_EXPIRE and ST_ISSUE, a tick through ST_EXPIRE and ST_ISSUE. ST_EXPIRE
// repeats for each outstanding command that expires, as the table is a row
// of cells that drops its oldest entry one cell shift per cycle. A request
// is taken in the cycle after the previous response is loaded, so no new
// request is accepted while one is in progress. When the receiver stalls,
// a finished response waits in the output register and the next request is
// still accepted; its response waits for the slot. Reset clears all counts,
// the tick counter and the FIFO pointers, and sets the timeout to 1000 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module hci_command_credit_tracker_unit #(
   parameter int OUTSTANDING_DEPTH = 8,
   parameter int PENDING_DEPTH     = 16,
   parameter int TICK_WIDTH        = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // command_opcode, event_code, event_opcode, event_credits, event_short
   input  wire [hcct_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode
   input  wire [1:0]                         req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // issue_valid, issue_opcode, queued, dropped, ack_matched, ack_unexpected,
   // timed_out_count, credit_now, outstanding_now, pending_now
   output logic [hcct_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                               csr_wen,
   input  wire [15:0]                        csr_wdata
);
   import hcct_pkg::*;

   localparam int OIW = (OUTSTANDING_DEPTH > 1) ? $clog2(OUTSTANDING_DEPTH) : 1;
   localparam int OCW = $clog2(OUTSTANDING_DEPTH + 1);
   localparam int PCW = $clog2(PENDING_DEPTH + 1);

   state_type             state_ff, state_in;
   logic [15:0]           cmd_op_ff, cmd_op_in;
   logic [7:0]            ev_code_ff, ev_code_in;
   logic [15:0]           ev_op_ff, ev_op_in;
   logic [7:0]            ev_cred_ff, ev_cred_in;
   logic                  ev_short_ff, ev_short_in;
   logic [15:0]           timeout_ff, timeout_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic [7:0]            credit_ff, credit_in;
   logic [OCW-1:0]        ocount_ff, ocount_in;
   logic [OCW-1:0]        expired_ff, expired_in;
   logic                  matched_ff, matched_in;
   logic                  unexp_ff, unexp_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   cell_ctrl_type         cell_ctrl [OUTSTANDING_DEPTH];
   logic [15:0]           cell_op   [OUTSTANDING_DEPTH];
   logic [TICK_WIDTH-1:0] cell_tick [OUTSTANDING_DEPTH];
   logic                  cell_hit  [OUTSTANDING_DEPTH];
   logic [15:0]           load_opcode;

   fifo_ctrl_type         fifo_ctrl;
   logic [15:0]           fifo_head;
   logic [PCW-1:0]        fifo_count;
   logic [PCW-1:0]        pend_next;

   logic                  out_free;
   logic                  ack_event;
   logic                  hit_found;
   logic [OIW-1:0]        hit_idx;
   logic                  head_expired;
   logic [7:0]            credit_eff;
   logic                  ctl_ready;
   logic                  res_write;
   logic                  res_issue;
   logic [15:0]           res_op;
   logic                  res_queued;
   logic                  res_dropped;

   for (genvar g = 0; g < OUTSTANDING_DEPTH; g++) begin : g_cell
      logic [15:0]           nxt_op;
      logic [TICK_WIDTH-1:0] nxt_tick;
      if (g == OUTSTANDING_DEPTH - 1) begin : g_end
         assign nxt_op   = '0;
         assign nxt_tick = '0;
      end else begin : g_mid
         assign nxt_op   = cell_op[g+1];
         assign nxt_tick = cell_tick[g+1];
      end
      hcct_cell #(
         .TICK_WIDTH (TICK_WIDTH)
      ) u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl[g]),
         .load_opcode  (load_opcode),
         .load_tick    (tick_ff),
         .next_opcode  (nxt_op),
         .next_tick    (nxt_tick),
         .match_opcode (ev_op_ff),
         .opcode       (cell_op[g]),
         .tick         (cell_tick[g]),
         .match        (cell_hit[g])
      );
   end

   hcct_fifo #(
      .DEPTH (PENDING_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fifo_ctrl),
      .push_data (cmd_op_ff),
      .head_data (fifo_head),
      .count     (fifo_count)
   );

   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign ack_event = ((ev_code_ff == EVT_CMD_COMPLETE) || (ev_code_ff == EVT_CMD_STATUS))
                      && !ev_short_ff;
   assign head_expired = (ocount_ff != '0)
                         && ((tick_ff - cell_tick[0]) > TICK_WIDTH'(timeout_ff));
   assign credit_eff = (ocount_ff == '0) ? 8'd1 : credit_ff;
   assign pend_next  = fifo_count + PCW'(fifo_ctrl.push) - PCW'(fifo_ctrl.pop);

   always_comb begin
      hit_found = 1'b0;
      hit_idx   = '0;
      for (int i = OUTSTANDING_DEPTH - 1; i >= 0; i--) begin
         if (cell_hit[i] && (OCW'(i) < ocount_ff)) begin
            hit_found = 1'b1;
            hit_idx   = OIW'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_op_in     = cmd_op_ff;
      ev_code_in    = ev_code_ff;
      ev_op_in      = ev_op_ff;
      ev_cred_in    = ev_cred_ff;
      ev_short_in   = ev_short_ff;
      timeout_in    = csr_wen ? csr_wdata : timeout_ff;
      tick_in       = tick_ff;
      credit_in     = credit_ff;
      ocount_in     = ocount_ff;
      expired_in    = expired_ff;
      matched_in    = matched_ff;
      unexp_in      = unexp_ff;
      req_tready    = 1'b0;
      load_opcode   = cmd_op_ff;
      fifo_ctrl     = '0;
      ctl_ready     = 1'b0;
      res_write     = 1'b0;
      res_issue     = 1'b0;
      res_op        = NULL_OPCODE;
      res_queued    = 1'b0;
      res_dropped   = 1'b0;
      for (int i = 0; i < OUTSTANDING_DEPTH; i++) begin
         cell_ctrl[i] = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_op_in   = req_tdata[15:0];
               ev_code_in  = req_tdata[23:16];
               ev_op_in    = req_tdata[39:24];
               ev_cred_in  = req_tdata[47:40];
               ev_short_in = req_tdata[48];
               expired_in  = '0;
               matched_in  = 1'b0;
               unexp_in    = 1'b0;
               case (req_tuser)
                  MODE_SUBMIT: state_in = ST_SUBMIT;
                  MODE_EVENT:  state_in = ST_MATCH;
                  MODE_TICK: begin
                     tick_in  = tick_ff + 1'b1;
                     state_in = ST_EXPIRE;
                  end
                  default:     state_in = ST_REPORT;
               endcase
            end
         end
         ST_SUBMIT: begin
            ctl_ready = (credit_ff > 8'(ocount_ff))
                        && (ocount_ff < OCW'(OUTSTANDING_DEPTH));
            if (out_free) begin
               res_write = 1'b1;
               state_in  = ST_IDLE;
               if (ctl_ready) begin
                  for (int i = 0; i < OUTSTANDING_DEPTH; i++) begin
                     cell_ctrl[i].load = (OCW'(i) == ocount_ff);
                  end
                  credit_in = credit_ff - 1'b1;
                  ocount_in = ocount_ff + 1'b1;
                  res_issue = 1'b1;
                  res_op    = cmd_op_ff;
               end else if (fifo_count == PCW'(PENDING_DEPTH)) begin
                  res_dropped = 1'b1;
               end else begin
                  fifo_ctrl.push = 1'b1;
                  res_queued     = 1'b1;
               end
            end
         end
         ST_MATCH: begin
            if (ack_event) begin
               if (hit_found) begin
                  for (int i = 0; i < OUTSTANDING_DEPTH; i++) begin
                     cell_ctrl[i].shift = (OIW'(i) >= hit_idx);
                  end
                  ocount_in  = ocount_ff - 1'b1;
                  matched_in = 1'b1;
               end else if (ev_op_ff != NULL_OPCODE) begin
                  unexp_in = 1'b1;
               end
               credit_in = ev_cred_ff;
            end
            state_in = ST_EXPIRE;
         end
         ST_EXPIRE: begin
            if (head_expired) begin
               for (int i = 0; i < OUTSTANDING_DEPTH; i++) begin
                  cell_ctrl[i].shift = 1'b1;
               end
               ocount_in  = ocount_ff - 1'b1;
               expired_in = expired_ff + 1'b1;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            ctl_ready = (credit_eff > 8'(ocount_ff))
                        && (ocount_ff < OCW'(OUTSTANDING_DEPTH));
            if (out_free) begin
               res_write = 1'b1;
               state_in  = ST_IDLE;
               credit_in = credit_eff;
               if ((fifo_count != '0) && ctl_ready) begin
                  load_opcode   = fifo_head;
                  fifo_ctrl.pop = 1'b1;
                  for (int i = 0; i < OUTSTANDING_DEPTH; i++) begin
                     cell_ctrl[i].load = (OCW'(i) == ocount_ff);
                  end
                  credit_in = credit_eff - 1'b1;
                  ocount_in = ocount_ff + 1'b1;
                  res_issue = 1'b1;
                  res_op    = fifo_head;
               end
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               res_write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (res_write) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {6'd0, 5'(pend_next), 4'(ocount_in), credit_in,
                          4'(expired_in), unexp_in, matched_in, res_dropped,
                          res_queued, res_op, res_issue};
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
         rsp_tdata_in  = rsp_tdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_op_ff    <= cmd_op_in;
      ev_code_ff   <= ev_code_in;
      ev_op_ff     <= ev_op_in;
      ev_cred_ff   <= ev_cred_in;
      ev_short_ff  <= ev_short_in;
      expired_ff   <= expired_in;
      matched_ff   <= matched_in;
      unexp_ff     <= unexp_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         timeout_ff    <= TIMEOUT_RESET;
         tick_ff       <= '0;
         credit_ff     <= '0;
         ocount_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         timeout_ff    <= timeout_in;
         tick_ff       <= tick_in;
         credit_ff     <= credit_in;
         ocount_ff     <= ocount_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

// ===== tb/hcct_flow_checker.sv =====
// ----------------------------------------------------------------------------
// HCI command credit tracker flow checker
// Watches the request, response and register ports of the tracker and keeps
// its own copy of the credit, outstanding table, pending queue and tick
// state. Each accepted request beat yields one predicted status, which is
// compared field by field with the next accepted response beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hcct_flow_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   // command_opcode, event_code, event_opcode, event_credits, event_short
   input  wire [hcct_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode
   input  wire [1:0]                        req_tuser,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   // issue_valid, issue_opcode, queued, dropped, ack_matched, ack_unexpected,
   // timed_out_count, credit_now, outstanding_now, pending_now
   input  wire [hcct_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                              csr_wen,
   input  wire [15:0]                       csr_wdata,
   output int                               fail_count,
   output int                               waiting_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import hcct_pkg::*;

   localparam int OUT_DEPTH  = 8;
   localparam int PEND_DEPTH = 16;

   // The first member sits in the highest bits of a packed struct.
   typedef struct packed {
      logic [4:0]  pending_now;
      logic [3:0]  outstanding_now;
      logic [7:0]  credit_now;
      logic [3:0]  timed_out_count;
      logic        ack_unexpected;
      logic        ack_matched;
      logic        dropped;
      logic        queued;
      logic [15:0] issue_opcode;
      logic        issue_valid;
   } status_type;

   logic [15:0] timeout_ticks;
   logic [15:0] cmd_op_tbl [OUT_DEPTH];
   logic [31:0] cmd_tick_tbl [OUT_DEPTH];
   int          outstanding_cnt;
   logic [7:0]  credits;
   logic [15:0] pend_fifo [PEND_DEPTH];
   int          pend_cnt;
   int          pend_head;
   logic [31:0] tick_now;
   status_type  expected_status_q [$];

   function automatic bit ctrl_ready();
      return (int'(credits) > outstanding_cnt) && (outstanding_cnt < OUT_DEPTH);
   endfunction

   function automatic void issue_cmd(input logic [15:0] op);
      cmd_op_tbl[outstanding_cnt]   = op;
      cmd_tick_tbl[outstanding_cnt] = tick_now;
      outstanding_cnt++;
      credits = credits - 8'd1;
   endfunction

   function automatic void retire_entry(input int idx);
      for (int i = idx; i + 1 < outstanding_cnt; i++) begin
         cmd_op_tbl[i]   = cmd_op_tbl[i + 1];
         cmd_tick_tbl[i] = cmd_tick_tbl[i + 1];
      end
      outstanding_cnt--;
   endfunction

   function automatic void run_upkeep(inout status_type st);
      logic [15:0] op;
      while (outstanding_cnt > 0 &&
             (tick_now - cmd_tick_tbl[0]) > {16'd0, timeout_ticks}) begin
         retire_entry(0);
         st.timed_out_count = st.timed_out_count + 4'd1;
      end
      if (outstanding_cnt == 0) begin
         credits = 8'd1;
      end
      if (pend_cnt > 0 && ctrl_ready()) begin
         op        = pend_fifo[pend_head];
         pend_head = (pend_head + 1) % PEND_DEPTH;
         pend_cnt--;
         issue_cmd(op);
         st.issue_valid  = 1'b1;
         st.issue_opcode = op;
      end
   endfunction

   function automatic status_type track_item(input logic [1:0] mode,
                                             input logic [REQ_DATA_W-1:0] d);
      status_type  st;
      logic [15:0] cmd_op;
      logic [7:0]  ev_code;
      logic [15:0] ev_op;
      logic [7:0]  ev_cred;
      logic        ev_short;
      int          idx;
      st       = '0;
      cmd_op   = d[15:0];
      ev_code  = d[23:16];
      ev_op    = d[39:24];
      ev_cred  = d[47:40];
      ev_short = d[48];
      case (mode)
         MODE_SUBMIT: begin
            if (ctrl_ready()) begin
               issue_cmd(cmd_op);
               st.issue_valid  = 1'b1;
               st.issue_opcode = cmd_op;
            end else if (pend_cnt >= PEND_DEPTH) begin
               st.dropped = 1'b1;
            end else begin
               pend_fifo[(pend_head + pend_cnt) % PEND_DEPTH] = cmd_op;
               pend_cnt++;
               st.queued = 1'b1;
            end
         end
         MODE_EVENT: begin
            if ((ev_code == EVT_CMD_COMPLETE || ev_code == EVT_CMD_STATUS) && !ev_short) begin
               idx = outstanding_cnt;
               for (int i = outstanding_cnt - 1; i >= 0; i--) begin
                  if (cmd_op_tbl[i] == ev_op) begin
                     idx = i;
                  end
               end
               if (idx < outstanding_cnt) begin
                  retire_entry(idx);
                  st.ack_matched = 1'b1;
               end else if (ev_op != NULL_OPCODE) begin
                  st.ack_unexpected = 1'b1;
               end
               credits = ev_cred;
            end
            run_upkeep(st);
         end
         MODE_TICK: begin
            tick_now = tick_now + 32'd1;
            run_upkeep(st);
         end
         default: begin
         end
      endcase
      st.credit_now      = credits;
      st.outstanding_now = 4'(outstanding_cnt);
      st.pending_now     = 5'(pend_cnt);
      return st;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (reset) begin
         timeout_ticks   = TIMEOUT_RESET;
         outstanding_cnt = 0;
         credits         = 8'd0;
         pend_cnt        = 0;
         pend_head       = 0;
         tick_now        = 32'd0;
         expected_status_q.delete();
      end else begin
         if (csr_wen) begin
            timeout_ticks = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = status_type'(rsp_tdata[$bits(status_type)-1:0]);
            if (expected_status_q.size() == 0) begin
               $error("response beat arrived with no status expected");
               fail_count++;
            end else begin
               want = expected_status_q[0];
               expected_status_q.delete(0);
               check_field("issue_valid", want.issue_valid, got.issue_valid);
               check_field("issue_opcode", want.issue_opcode, got.issue_opcode);
               check_field("queued", want.queued, got.queued);
               check_field("dropped", want.dropped, got.dropped);
               check_field("ack_matched", want.ack_matched, got.ack_matched);
               check_field("ack_unexpected", want.ack_unexpected, got.ack_unexpected);
               check_field("timed_out_count", want.timed_out_count, got.timed_out_count);
               check_field("credit_now", want.credit_now, got.credit_now);
               check_field("outstanding_now", want.outstanding_now, got.outstanding_now);
               check_field("pending_now", want.pending_now, got.pending_now);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_status_q.push_back(track_item(req_tuser, req_tdata));
         end
      end
      waiting_count = expected_status_q.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// HCI command credit tracker testbench
// Drives directed and random submit, event, tick and unused-code beats into
// the tracker under several timeout settings and idle patterns, including one
// long response stall, and reports the verdict from the flow checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import hcct_pkg::*;

   localparam logic [1:0] MODE_UNUSED     = 2'd3;
   localparam int         NUM_PHASES      = 8;
   localparam int         ITEMS_PER_PHASE = 75;
   localparam int         SETTLE_CYCLES   = 16;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wen = 1'b0;
   logic [15:0]           csr_wdata = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire [RSP_DATA_W-1:0]  rsp_tdata;
   int                    fail_count;
   int                    waiting_count;
   int                    send_idle_pct = 0;
   int                    rcv_stall_pct = 0;
   bit                    hold_go = 1'b0;
   int                    hold_left = 0;
   logic [15:0]           op_pool [8];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hci_command_credit_tracker_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   hcct_flow_checker u_flow_chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .waiting_count (waiting_count)
   );

   // A long stall lets the sender fill the tracker until its input stalls.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else if (hold_go) begin
            hold_go    = 1'b0;
            hold_left  = 300;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= rcv_stall_pct);
         end
      end
   end

   task automatic send_beat(input logic [1:0] mode, input logic [15:0] cmd_op,
                            input logic [7:0] ev_code, input logic [15:0] ev_op,
                            input logic [7:0] ev_cred, input logic ev_short);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {7'd0, ev_short, ev_cred, ev_op, ev_code, cmd_op};
      do begin
         @(posedge clock);
      end while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_random();
      int          pick;
      int          sel;
      logic [15:0] op;
      logic [7:0]  code;
      logic [7:0]  cred;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         if ($urandom_range(0, 99) < 60) begin
            op = 16'($urandom);
            op_pool[$urandom_range(0, 7)] = op;
         end else begin
            op = op_pool[$urandom_range(0, 7)];
         end
         send_beat(MODE_SUBMIT, op, 8'($urandom), 16'($urandom), 8'($urandom),
                   1'($urandom));
      end else if (pick < 68) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            code = EVT_CMD_COMPLETE;
         end else if (sel < 85) begin
            code = EVT_CMD_STATUS;
         end else begin
            code = 8'($urandom);
         end
         sel = $urandom_range(0, 99);
         if (sel < 65) begin
            op = op_pool[$urandom_range(0, 7)];
         end else if (sel < 80) begin
            op = NULL_OPCODE;
         end else begin
            op = 16'($urandom);
         end
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            cred = 8'($urandom_range(0, 12));
         end else if (sel < 90) begin
            cred = 8'($urandom);
         end else begin
            cred = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         end
         send_beat(MODE_EVENT, 16'($urandom), code, op, cred,
                   ($urandom_range(0, 99) < 10));
      end else if (pick < 96) begin
         send_beat(MODE_TICK, 16'($urandom), 8'($urandom), 16'($urandom),
                   8'($urandom), 1'($urandom));
      end else begin
         send_beat(MODE_UNUSED, 16'($urandom), 8'($urandom), 16'($urandom),
                   8'($urandom), 1'($urandom));
      end
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (waiting_count != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [15:0] timeout_val;
      int          drain;
      for (int i = 0; i < 8; i++) begin
         op_pool[i] = 16'($urandom);
      end
      repeat (10) @(negedge clock);
      reset = 1'b0;

      send_beat(MODE_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
      send_beat(MODE_TICK, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0);
      send_beat(MODE_SUBMIT, 16'hFFFF, 8'h00, 16'h0000, 8'h00, 1'b0);
      send_beat(MODE_SUBMIT, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0);
      send_beat(MODE_EVENT, 16'h0000, EVT_CMD_COMPLETE, 16'hFFFF, 8'hFF, 1'b0);
      send_beat(MODE_EVENT, 16'h0000, EVT_CMD_STATUS, 16'h0000, 8'h09, 1'b1);
      send_beat(MODE_EVENT, 16'h0000, 8'hFF, 16'h0000, 8'h09, 1'b0);
      send_beat(MODE_EVENT, 16'h0000, EVT_CMD_STATUS, 16'hABCD, 8'h00, 1'b0);
      send_beat(MODE_EVENT, 16'h0000, EVT_CMD_COMPLETE, NULL_OPCODE, 8'h00, 1'b0);
      send_beat(MODE_EVENT, 16'h0000, EVT_CMD_COMPLETE, NULL_OPCODE, 8'h00, 1'b0);
      send_beat(MODE_SUBMIT, 16'h5A5A, 8'h00, 16'h0000, 8'h00, 1'b0);
      // With no credit left, the pending queue fills and the last submit is lost.
      for (int i = 0; i < 17; i++) begin
         send_beat(MODE_SUBMIT, 16'h8000 | 16'(i * 16'h0421), 8'h00, 16'h0000,
                   8'h00, 1'b0);
      end
      send_beat(MODE_EVENT, 16'h0000, EVT_CMD_STATUS, 16'h1234, 8'hFF, 1'b0);
      send_beat(MODE_SUBMIT, 16'hC3C3, 8'h00, 16'h0000, 8'h00, 1'b0);
      send_beat(MODE_TICK, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0:       timeout_val = 16'd1;
            1:       timeout_val = 16'd65535;
            2:       timeout_val = 16'd2;
            3:       timeout_val = 16'd6;
            4:       timeout_val = 16'd1;
            5:       timeout_val = 16'd40;
            6:       timeout_val = 16'($urandom_range(1, 20));
            default: timeout_val = 16'd3;
         endcase
         csr_wen   = 1'b1;
         csr_wdata = timeout_val;
         @(negedge clock);
         csr_wen = 1'b0;
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rcv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 48;
               rcv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rcv_stall_pct = 48;
            end
            default: begin
               send_idle_pct = 21;
               rcv_stall_pct = 21;
            end
         endcase
         if (phase == 4) begin
            hold_go = 1'b1;
         end
         repeat (ITEMS_PER_PHASE) send_random();
      end

      req_tvalid = 1'b0;
      drain = 0;
      while (waiting_count != 0 && drain < 5000) begin
         @(negedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && waiting_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/hcct_pkg.sv
hdl/hcct_cell.sv
hdl/hcct_fifo.sv
hdl/hci_command_credit_tracker_unit.sv
tb/hcct_flow_checker.sv
tb/tb_top.sv
